// ===== hdl/gcw_pkg.sv =====
// Shared types, widths and constants of the generalized cosine window block.
package gcw_pkg;

    localparam int TAP_W      = 12;
    localparam int HW_W       = 11;
    localparam int COEF_W     = 20;
    localparam int WEIGHT_W   = 23;
    localparam int ANG_W      = 17;
    localparam int COS_W      = 32;
    localparam int PROD_W     = COEF_W + COS_W;
    localparam int ACC_W      = 54;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int FIFO_DEPTH = 4;

    localparam int MAX_HALF_WIDTH_DEF  = 1024;
    localparam int COS_TABLE_DEPTH_DEF = 1024;

    localparam longint PI_Q30   = 64'sd3373259426;
    localparam longint ONE_Q30  = 64'sd1073741824;
    localparam longint HALF_Q30 = 64'sd536870912;
    localparam longint W_MAX    = 64'sd4194303;
    localparam longint W_MIN    = -64'sd4194304;

    localparam logic [HW_W-1:0]   HALF_WIDTH_RST = 11'd16;
    localparam logic [COEF_W-1:0] COEF_A0_RST    = 20'd32768;
    localparam logic [COEF_W-1:0] COEF_A1_RST    = 20'd32768;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_WIDTH = 3'd0,
        REG_COEF_A0    = 3'd1,
        REG_COEF_A1    = 3'd2,
        REG_COEF_A2    = 3'd3,
        REG_COEF_A3    = 3'd4,
        REG_COEF_A4    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] a0;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic signed [COEF_W-1:0] a3;
        logic signed [COEF_W-1:0] a4;
    } coef_set_t;

    typedef struct packed {
        logic [HW_W-1:0] mag;
        logic            outside;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// ===== hdl/gcw_front.sv =====
// Front end: takes tap beats, folds the sign, clamps the half width, flags outside taps.
module gcw_front import gcw_pkg::*; #(
    parameter int MAX_HALF_WIDTH = MAX_HALF_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [TAP_W-1:0] tap,
    input  logic [HW_W-1:0]         half_width,
    input  logic                    fifo_full,
    output logic                    push,
    output item_t                   push_item,
    output logic [HW_W-1:0]         h_eff
);

    logic              vld_reg;
    item_t             item_reg;
    logic [TAP_W-1:0]  mag_in;
    logic              outside_in;

    always_comb begin
        if (half_width == '0) begin
            h_eff = HW_W'(1);
        end else if (32'(half_width) > MAX_HALF_WIDTH) begin
            h_eff = HW_W'(MAX_HALF_WIDTH);
        end else begin
            h_eff = half_width;
        end
        mag_in     = tap[TAP_W-1] ? TAP_W'(-tap) : TAP_W'(tap);
        outside_in = mag_in > {1'b0, h_eff};
    end

    assign s_ready   = !vld_reg || !fifo_full;
    assign push      = vld_reg && !fifo_full;
    assign push_item = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            vld_reg <= 1'b1;
        end else if (push) begin
            vld_reg <= 1'b0;
        end
    end

    // Outside taps carry a zero magnitude so the divider stays in range.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.outside <= outside_in;
            item_reg.mag     <= outside_in ? '0 : mag_in[HW_W-1:0];
        end
    end

endmodule

// ===== hdl/gcw_fifo.sv =====
// Short queue between the front end and the arithmetic pipeline.
module gcw_fifo import gcw_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  item_t      push_item,
    input  logic       pop,
    output item_t      head,
    output fifo_stat_t stat
);

    localparam int FP_W = $clog2(FIFO_DEPTH);
    localparam int FC_W = $clog2(FIFO_DEPTH + 1);

    item_t            mem [FIFO_DEPTH];
    logic [FP_W-1:0]  wr_ptr_reg;
    logic [FP_W-1:0]  rd_ptr_reg;
    logic [FC_W-1:0]  cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign stat.full  = cnt_reg == FC_W'(FIFO_DEPTH);
    assign stat.empty = cnt_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= FP_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop) begin
                rd_ptr_reg <= FP_W'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= FC_W'(cnt_reg + 1'b1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= FC_W'(cnt_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== hdl/gcw_cos.sv =====
// Cosine of a 17-bit angle from a quarter-wave ROM with linear interpolation, 4 stages.
module gcw_cos import gcw_pkg::*; #(
    parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [ANG_W-1:0]        ang,
    output logic signed [COS_W-1:0] cos_val
);

    localparam int IW = $clog2(COS_TABLE_DEPTH + 1);
    localparam int PW = 15 + IW;

    // Power series denominators (2n-1)*2n for n = 1..12.
    localparam longint SER_DEN [12] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552};

    typedef logic [30:0] rom_t [COS_TABLE_DEPTH + 1];

    function automatic rom_t build_rom();
        rom_t   t;
        longint x;
        longint x2;
        longint term;
        longint sum;
        for (int j = 0; j <= COS_TABLE_DEPTH; j++) begin
            x    = (PI_Q30 * j + COS_TABLE_DEPTH) / (2 * COS_TABLE_DEPTH);
            x2   = (x * x + HALF_Q30) / ONE_Q30;
            term = ONE_Q30;
            sum  = ONE_Q30;
            for (int n = 1; n <= 12; n++) begin
                term = (term * x2 + HALF_Q30) / ONE_Q30;
                term = term / SER_DEN[n-1];
                if (n % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > ONE_Q30) begin
                sum = ONE_Q30;
            end
            t[j] = 31'(sum);
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [15:0]    offq;
    logic [PW-1:0]  pos;
    logic [IW-1:0]  idx1;
    logic [30:0]    diff;
    logic [30:0]    step;
    logic [30:0]    val;

    logic [IW-1:0]  idx_reg;
    logic [14:0]    fr1_reg, fr2_reg;
    logic           neg1_reg, neg2_reg, neg3_reg;
    logic [30:0]    lo_reg, hi_reg, lo3_reg;
    logic           dir_reg;
    logic [45:0]    prod_reg;
    logic signed [COS_W-1:0] cos_reg;

    // Fold the angle into the first quadrant; quadrants two and three flip sign.
    always_comb begin
        offq = ang[15] ? 16'(17'd32768 - {2'b0, ang[14:0]}) : {1'b0, ang[14:0]};
        pos  = PW'(offq * COS_TABLE_DEPTH);
        idx1 = (idx_reg == IW'(COS_TABLE_DEPTH)) ? idx_reg : IW'(idx_reg + 1'b1);
        diff = (lo_reg >= hi_reg) ? lo_reg - hi_reg : hi_reg - lo_reg;
        step = prod_reg[45:15];
        val  = dir_reg ? lo3_reg - step : lo3_reg + step;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_reg  <= pos[PW-1:15];
            fr1_reg  <= pos[14:0];
            neg1_reg <= ang[16] ^ ang[15];

            lo_reg   <= ROM[idx_reg];
            hi_reg   <= ROM[idx1];
            fr2_reg  <= fr1_reg;
            neg2_reg <= neg1_reg;

            prod_reg <= 46'(diff * fr2_reg);
            dir_reg  <= lo_reg >= hi_reg;
            lo3_reg  <= lo_reg;
            neg3_reg <= neg2_reg;

            cos_reg  <= neg3_reg ? -$signed({1'b0, val}) : $signed({1'b0, val});
        end
    end

    assign cos_val = cos_reg;

endmodule

// ===== hdl/gcw_back.sv =====
// Back end: phase divider, four cosine lanes, weighting, sum, rounding and output register.
module gcw_back import gcw_pkg::*; #(
    parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [HW_W-1:0]            h,
    input  coef_set_t                  coef,
    input  item_t                      head,
    input  fifo_stat_t                 fifo_stat,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [WEIGHT_W-1:0] weight,
    output logic                       outside
);

    localparam int DIV_N = ANG_W;
    localparam int LAT   = DIV_N + 8;

    logic en;

    logic              vld_reg [LAT];
    logic              ofl_reg [LAT];
    logic [HW_W-1:0]   rem_reg [DIV_N];
    logic [ANG_W-1:0]  quo_reg [DIV_N];
    logic [HW_W-1:0]   rem_next [DIV_N];
    logic [ANG_W-1:0]  quo_next [DIV_N];

    logic [ANG_W-1:0]  ang_reg [4];
    logic signed [COS_W-1:0]  cos_val [4];
    logic signed [PROD_W-1:0] prod_reg [4];
    logic signed [ACC_W-1:0]  s01_reg, s34_reg, acc_reg;
    logic signed [ACC_W-1:0]  a0_term, rnd, quo_w;

    logic                       m_valid_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic                       outside_reg;

    assign en  = !m_valid_reg || m_ready;
    assign pop = en && !fifo_stat.empty;

    // Restoring division of mag * 2^16 by h, one quotient bit per stage.
    always_comb begin
        logic [HW_W:0] t;
        logic          ge;
        ge          = head.mag >= h;
        rem_next[0] = ge ? head.mag - h : head.mag;
        quo_next[0] = {ge, {(ANG_W-1){1'b0}}};
        for (int i = 1; i < DIV_N; i++) begin
            t           = {rem_reg[i-1], 1'b0};
            ge          = t >= {1'b0, h};
            rem_next[i] = ge ? HW_W'(t - {1'b0, h}) : t[HW_W-1:0];
            quo_next[i] = quo_reg[i-1] | (ANG_W'(ge) << (DIV_N - 1 - i));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= pop;
            for (int i = 1; i < LAT; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ofl_reg[0] <= head.outside;
            for (int i = 1; i < LAT; i++) begin
                ofl_reg[i] <= ofl_reg[i-1];
            end
            for (int i = 0; i < DIV_N; i++) begin
                rem_reg[i] <= rem_next[i];
                quo_reg[i] <= quo_next[i];
            end
        end
    end

    // Harmonic angles wrap modulo a full turn.
    always_ff @(posedge aclk) begin
        if (en) begin
            ang_reg[0] <= quo_reg[DIV_N-1];
            ang_reg[1] <= {quo_reg[DIV_N-1][ANG_W-2:0], 1'b0};
            ang_reg[2] <= ANG_W'(quo_reg[DIV_N-1] + {quo_reg[DIV_N-1][ANG_W-2:0], 1'b0});
            ang_reg[3] <= {quo_reg[DIV_N-1][ANG_W-3:0], 2'b0};
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        gcw_cos #(
            .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
        ) u_cos (
            .aclk   (aclk),
            .en     (en),
            .ang    (ang_reg[k]),
            .cos_val(cos_val[k])
        );
    end

    assign a0_term = ACC_W'(coef.a0) <<< 30;
    assign rnd     = acc_reg + ACC_W'(HALF_Q30);
    assign quo_w   = rnd >>> 30;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg[0] <= coef.a1 * cos_val[0];
            prod_reg[1] <= coef.a2 * cos_val[1];
            prod_reg[2] <= coef.a3 * cos_val[2];
            prod_reg[3] <= coef.a4 * cos_val[3];
            s01_reg <= a0_term + ACC_W'(prod_reg[0]) + ACC_W'(prod_reg[1]);
            s34_reg <= ACC_W'(prod_reg[2]) + ACC_W'(prod_reg[3]);
            acc_reg <= s01_reg + s34_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= vld_reg[LAT-1];
        end
    end

    // Zero outside taps, otherwise saturate the rounded sum.
    always_ff @(posedge aclk) begin
        if (en) begin
            outside_reg <= ofl_reg[LAT-1];
            if (ofl_reg[LAT-1]) begin
                weight_reg <= '0;
            end else if (quo_w > ACC_W'(W_MAX)) begin
                weight_reg <= WEIGHT_W'(W_MAX);
            end else if (quo_w < ACC_W'(W_MIN)) begin
                weight_reg <= WEIGHT_W'(W_MIN);
            end else begin
                weight_reg <= quo_w[WEIGHT_W-1:0];
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign weight  = weight_reg;
    assign outside = outside_reg;

endmodule

// ===== hdl/generalized_cosine_window.sv =====
// Five-term generalized cosine window: one weight beat per tap beat.
// Throughput: one tap per clock while the output is not stalled; set by the divider, one quotient bit per stage.
// Path from accepted tap to output beat: front register, queue, 17 divider stages, angle,
// 4 table stages, multiply, 2 adds, output register.
// Reset: synchronous, active low; clears the queue and all valids and loads the Hann
// coefficients with half width 16. The cosine table is constant, so no clearing pass.
module generalized_cosine_window import gcw_pkg::*; #(
    parameter int MAX_HALF_WIDTH  = MAX_HALF_WIDTH_DEF,
    parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [11:0] tap_index
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [22:0] weight
    output logic                  m_tuser,   // [0] outside
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [HW_W-1:0]            half_width_reg;
    coef_set_t                  coef_reg;
    logic [HW_W-1:0]            h_eff;
    logic                       push;
    item_t                      push_item;
    item_t                      head;
    fifo_stat_t                 fifo_stat;
    logic                       pop;
    logic signed [WEIGHT_W-1:0] weight;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg <= HALF_WIDTH_RST;
            coef_reg.a0    <= COEF_A0_RST;
            coef_reg.a1    <= COEF_A1_RST;
            coef_reg.a2    <= '0;
            coef_reg.a3    <= '0;
            coef_reg.a4    <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HALF_WIDTH: half_width_reg <= cfg_wdata[HW_W-1:0];
                REG_COEF_A0:    coef_reg.a0 <= cfg_wdata;
                REG_COEF_A1:    coef_reg.a1 <= cfg_wdata;
                REG_COEF_A2:    coef_reg.a2 <= cfg_wdata;
                REG_COEF_A3:    coef_reg.a3 <= cfg_wdata;
                REG_COEF_A4:    coef_reg.a4 <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    gcw_front #(
        .MAX_HALF_WIDTH(MAX_HALF_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .tap       (s_tdata[TAP_W-1:0]),
        .half_width(half_width_reg),
        .fifo_full (fifo_stat.full),
        .push      (push),
        .push_item (push_item),
        .h_eff     (h_eff)
    );

    gcw_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_item(push_item),
        .pop      (pop),
        .head     (head),
        .stat     (fifo_stat)
    );

    gcw_back #(
        .COS_TABLE_DEPTH(COS_TABLE_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .h        (h_eff),
        .coef     (coef_reg),
        .head     (head),
        .fifo_stat(fifo_stat),
        .pop      (pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .weight   (weight),
        .outside  (m_tuser)
    );

    assign m_tdata = {1'b0, weight};

    a_outside_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("outside tap with nonzero weight");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && fifo_stat.full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && fifo_stat.empty))
        else $error("queue pop while empty");

    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid && fifo_stat.empty)
        else $error("output or queue busy after reset");

endmodule

// ===== tb/sv/gcw_weight_checker.sv =====
// Predicts each window weight from accepted tap beats and compares the output beats.
`timescale 1ns / 100ps
module gcw_weight_checker import gcw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [15:0]           s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,
    input  logic                  m_tuser,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending_count
);

    localparam int TBL_N = COS_TABLE_DEPTH_DEF;

    typedef struct {
        logic [WEIGHT_W-1:0] weight;
        logic                outside;
    } weight_beat_t;

    longint cos_tbl [0:TBL_N];
    logic [HW_W-1:0] half_w;
    coef_set_t       coefs;
    weight_beat_t    expected_q [$];

    // Quarter-wave cosine table in Q30, truncated power series.
    initial begin
        longint x, x2, term, sum;
        for (int j = 0; j <= TBL_N; j++) begin
            x   = (PI_Q30 * j + TBL_N) / (2 * TBL_N);
            x2  = (x * x + HALF_Q30) / ONE_Q30;
            term = ONE_Q30;
            sum  = ONE_Q30;
            for (int n = 1; n <= 12; n++) begin
                term = (term * x2 + HALF_Q30) / ONE_Q30;
                term = term / ((2 * n - 1) * (2 * n));
                if (n % 2 == 1) sum = sum - term;
                else sum = sum + term;
            end
            if (sum < 0) sum = 0;
            if (sum > ONE_Q30) sum = ONE_Q30;
            cos_tbl[j] = sum;
        end
    end

    function automatic longint quarter_cos(longint off);
        longint pos, idx, fr, lo, hi;
        pos = off * TBL_N;
        idx = pos >>> 15;
        fr  = pos & 32'h7FFF;
        if (idx >= TBL_N) return cos_tbl[TBL_N];
        lo = cos_tbl[idx];
        hi = cos_tbl[idx + 1];
        if (lo >= hi) return lo - ((lo - hi) * fr) / 32768;
        return lo + ((hi - lo) * fr) / 32768;
    endfunction

    function automatic longint angle_cos(longint ang);
        longint a, off;
        a   = ang & 32'h1FFFF;
        off = a & 32'h7FFF;
        case (a >> 15)
            0: return quarter_cos(off);
            1: return -quarter_cos(32768 - off);
            2: return -quarter_cos(off);
            default: return quarter_cos(32768 - off);
        endcase
    endfunction

    function automatic weight_beat_t window_weight(logic signed [TAP_W-1:0] tap);
        weight_beat_t b;
        longint mag, h, p, acc, r, q;
        mag = (tap < 0) ? -longint'(tap) : longint'(tap);
        h = half_w;
        if (h < 1) h = 1;
        if (h > MAX_HALF_WIDTH_DEF) h = MAX_HALF_WIDTH_DEF;
        if (mag > h) begin
            b.weight = '0;
            b.outside = 1'b1;
            return b;
        end
        p = (mag << 16) / h;
        acc = longint'(coefs.a0) * ONE_Q30
            + longint'(coefs.a1) * angle_cos(p)
            + longint'(coefs.a2) * angle_cos(2 * p)
            + longint'(coefs.a3) * angle_cos(3 * p)
            + longint'(coefs.a4) * angle_cos(4 * p);
        r = acc + HALF_Q30;
        // floor division (arithmetic shift floors)
        q = r >>> 30;
        if (q > W_MAX) q = W_MAX;
        if (q < W_MIN) q = W_MIN;
        b.weight = q[WEIGHT_W-1:0];
        b.outside = 1'b0;
        return b;
    endfunction

    assign pending_count = expected_q.size();

    always @(posedge aclk) begin
        weight_beat_t e;
        if (!aresetn) begin
            half_w <= HALF_WIDTH_RST;
            coefs  <= '{COEF_A0_RST, COEF_A1_RST, 20'sd0, 20'sd0, 20'sd0};
            expected_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_HALF_WIDTH: half_w   <= cfg_wdata[HW_W-1:0];
                    REG_COEF_A0:    coefs.a0 <= cfg_wdata;
                    REG_COEF_A1:    coefs.a1 <= cfg_wdata;
                    REG_COEF_A2:    coefs.a2 <= cfg_wdata;
                    REG_COEF_A3:    coefs.a3 <= cfg_wdata;
                    REG_COEF_A4:    coefs.a4 <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(window_weight(s_tdata[TAP_W-1:0]));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected weight beat: actual %h/%b", $time,
                             m_tdata[WEIGHT_W-1:0], m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (m_tdata[WEIGHT_W-1:0] !== e.weight || m_tuser !== e.outside) begin
                        $display("%0t: weight mismatch: expected %h/%b actual %h/%b", $time,
                                 e.weight, e.outside, m_tdata[WEIGHT_W-1:0], m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/generalized_cosine_window_tb.sv =====
// Stimulus and verdict for the generalized cosine window block.
`timescale 1ns / 100ps
module generalized_cosine_window_tb;
    import gcw_pkg::*;

    localparam int LATENCY = 28;
    localparam longint CYCLE_LIMIT = 400000;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    fail_count;
    int                    pending_count;
    longint                cycle_count = 0;
    int                    cur_half = 16;

    always #5 aclk = ~aclk;

    generalized_cosine_window DUT (.*);

    gcw_weight_checker u_checker (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("generalized_cosine_window_tb failed");
            $finish;
        end
    end

    // Receiver: random stall before each beat, with quiet stretches.
    initial begin
        int stall;
        forever begin
            @(negedge aclk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_HALF_WIDTH) cur_half = val[HW_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_coefs(int a0, int a1, int a2, int a3, int a4);
        write_reg(REG_COEF_A0, a0[19:0]);
        write_reg(REG_COEF_A1, a1[19:0]);
        write_reg(REG_COEF_A2, a2[19:0]);
        write_reg(REG_COEF_A3, a3[19:0]);
        write_reg(REG_COEF_A4, a4[19:0]);
    endtask

    task automatic send_tap(logic [TAP_W-1:0] tap, bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, tap};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop valid right away so the last beat is not offered twice.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_count != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    // Mostly in-window taps; some anywhere in the 12-bit range.
    function automatic logic [TAP_W-1:0] random_tap();
        int h, v;
        h = (cur_half < 1) ? 1 : (cur_half > 1024 ? 1024 : cur_half);
        if ($urandom_range(0, 4) == 0) return TAP_W'($urandom);
        v = $urandom_range(0, h + 1);
        if ($urandom_range(0, 1)) v = -v;
        return TAP_W'(v);
    endfunction

    initial begin
        logic [TAP_W-1:0] directed [$];
        int hw_list [8];
        bit burst;
        hw_list = '{0, 1, 3, 16, 100, 1023, 1024, 2047};
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset Hann window: center, edges, just outside, extremes.
        directed = '{12'd0, 12'd1, 12'd8, 12'd16, 12'd17, -12'sd16, -12'sd17,
                     12'h7FF, 12'h800, 12'hFFF, 12'd1024, -12'sd1024};
        foreach (directed[k]) send_tap(directed[k], 1'b0);
        drain();

        // Saturation at both ends, and unknown register indices.
        write_coefs(524287, 524287, 524287, 524287, 524287);
        @(negedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= 3'd6; cfg_wdata <= '1;
        @(negedge aclk);
        cfg_index <= 3'd7;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        foreach (directed[k]) if (k < 5) send_tap(directed[k], 1'b0);
        drain();
        write_coefs(-524288, -524288, -524288, -524288, -524288);
        for (int t = 0; t <= 16; t += 4) send_tap(TAP_W'(t), 1'b0);
        drain();

        for (int phase = 0; phase < 16; phase++) begin
            write_reg(REG_HALF_WIDTH, CFG_DATA_W'(hw_list[phase % 8]));
            case (phase % 4)
                0: write_coefs(35389, 30147, 0, 0, 0);
                1: write_coefs(23511, 32001, 9259, 765, 0);
                2: write_coefs(int'($urandom_range(0, 1048575)) - 524288,
                               int'($urandom_range(0, 1048575)) - 524288,
                               int'($urandom_range(0, 1048575)) - 524288,
                               int'($urandom_range(0, 1048575)) - 524288,
                               int'($urandom_range(0, 1048575)) - 524288);
                default: write_coefs(14062, 27340, 16981, 5516, 455);
            endcase
            burst = (phase % 3 == 0);
            repeat (100) send_tap(random_tap(), burst);
            drain();
        end

        repeat (LATENCY + 10) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("generalized_cosine_window_tb passed");
        end else begin
            $display("generalized_cosine_window_tb failed");
        end
        $finish;
    end

endmodule

// ===== generalized_cosine_window.f =====
hdl/gcw_pkg.sv
hdl/gcw_front.sv
hdl/gcw_fifo.sv
hdl/gcw_cos.sv
hdl/gcw_back.sv
hdl/generalized_cosine_window.sv
tb/sv/gcw_weight_checker.sv
tb/sv/generalized_cosine_window_tb.sv
